### rtl/evag_pkg.sv
// ----------------------------------------------------------------------------
// evag_pkg
// Shared constants, register codes and types of the energy voice activity gate.
// ----------------------------------------------------------------------------
package evag_pkg;

  localparam int unsigned MaxChunkSamples = 4096;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SQ_W       = 2 * SAMPLE_W;
  localparam int unsigned ENERGY_W   = 43;
  localparam int unsigned CNT_W      = $clog2(MaxChunkSamples + 1);
  localparam int unsigned LEN_CFG_W  = 13;
  localparam int unsigned LEN_W      = (CNT_W > LEN_CFG_W) ? CNT_W : LEN_CFG_W;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned T2_W       = 2 * THR_W;
  localparam int unsigned PROD_W     = T2_W + CNT_W;
  localparam int unsigned CMP_W      = (ENERGY_W > PROD_W) ? ENERGY_W : PROD_W;
  localparam int unsigned PERIOD_W   = 4;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [LEN_CFG_W-1:0] ChunkSamplesRst   = LEN_CFG_W'(512);
  localparam logic [THR_W-1:0]     RmsThresholdRst   = THR_W'(800);
  localparam logic                 DetectEnableRst   = 1'b1;
  localparam logic [PERIOD_W-1:0]  DecisionPeriodRst = PERIOD_W'(4);

  localparam logic [ENERGY_W-1:0]  EnergyMax = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgChunkSamples   = 2'd0,
    CfgRmsThreshold   = 2'd1,
    CfgDetectEnable   = 2'd2,
    CfgDecisionPeriod = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [PROD_W-1:0]   limit;
    logic                mute;
  } chunk_t;

  typedef struct packed {
    logic chunk_is_speech;
    logic speaking_changed;
    logic speaking_now;
  } result_t;

endpackage

### rtl/evag_ifs.sv
// ----------------------------------------------------------------------------
// evag channel interfaces
// Valid/ready channels for sample beats in and chunk decision beats out.
// ----------------------------------------------------------------------------
interface evag_in_if
  import evag_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       mute;

  modport source (output valid, output sample, output mute, input ready);
  modport sink   (input valid, input sample, input mute, output ready);
endinterface

interface evag_out_if;
  logic valid;
  logic ready;
  logic chunk_is_speech;
  logic speaking_changed;
  logic speaking_now;

  modport source (output valid, output chunk_is_speech, output speaking_changed,
                  output speaking_now, input ready);
  modport sink   (input valid, input chunk_is_speech, input speaking_changed,
                  input speaking_now, output ready);
endinterface

### rtl/evag_decide.sv
// ----------------------------------------------------------------------------
// evag_decide
// Per-chunk speech decision, decision-period tally and speaking flag.
// ----------------------------------------------------------------------------
module evag_decide
  import evag_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  chunk_t              chunk_i,
  input  logic                detect_i,
  input  logic [PERIOD_W-1:0] period_i,
  output result_t             result_o
);

  logic [PERIOD_W-1:0] tally_q, tally_d;
  logic                flag_q, flag_d;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] tally_inc;
  logic                above;
  logic                speech;
  logic                changed;

  always_comb begin
    period    = (period_i == '0) ? PERIOD_W'(1) : period_i;
    tally_inc = tally_q + PERIOD_W'(1);
    above     = CMP_W'(chunk_i.energy) > CMP_W'(chunk_i.limit);
    tally_d   = tally_q;
    flag_d    = flag_q;
    changed   = 1'b0;
    speech    = 1'b0;
    if (chunk_i.mute) begin
      flag_d  = 1'b0;
      changed = flag_q;
    end else begin
      speech  = detect_i ? above : 1'b1;
      tally_d = tally_inc;
      if (tally_inc >= period) begin
        tally_d = '0;
        flag_d  = speech;
        changed = speech != flag_q;
      end
    end
    result_o.chunk_is_speech  = speech;
    result_o.speaking_changed = changed;
    result_o.speaking_now     = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      flag_q  <= 1'b0;
    end else if (en_i) begin
      tally_q <= tally_d;
      flag_q  <= flag_d;
    end
  end

endmodule

### rtl/energy_voice_activity_gate.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_gate
// RMS energy voice activity gate: sums squared samples per chunk and reports
// speech, speaking change and speaking state at each chunk end.
// A chunk's last sample beat passes the input, square, accumulate and limit registers into the result register.
// Throughput: one sample beat per cycle while decision beats are taken, set by the single square-accumulate.
// Reset: chunk state, speaking state, valid flags and config registers return to defaults; data registers do not.
// ----------------------------------------------------------------------------
module energy_voice_activity_gate
  import evag_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  evag_in_if.sink               in_ch,
  evag_out_if.source            out_ch
);

  logic [LEN_CFG_W-1:0] chunk_samples_q;
  logic [THR_W-1:0]     rms_threshold_q;
  logic                 detect_enable_q;
  logic [PERIOD_W-1:0]  decision_period_q;
  logic [T2_W-1:0]      t2_q;

  logic                       v1_q, v2_q, v3_q, v4_q, ov_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic                       s1_mute_q;
  logic [SQ_W-1:0]            s2_sq_q;
  logic                       s2_mute_q;
  logic [ENERGY_W-1:0]        energy_q, energy_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [ENERGY_W-1:0]        s3_energy_q;
  logic [CNT_W-1:0]           s3_count_q;
  logic                       s3_mute_q;
  chunk_t                     s4_q;
  result_t                    out_q;
  result_t                    result;

  logic                in_ready, adv_out, en4, en3, en2, go2, chunk_end;
  logic [SAMPLE_W-1:0] mag;
  logic [ENERGY_W:0]   energy_sum;
  logic [LEN_W-1:0]    len_cfg, eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_samples_q   <= ChunkSamplesRst;
      rms_threshold_q   <= RmsThresholdRst;
      detect_enable_q   <= DetectEnableRst;
      decision_period_q <= DecisionPeriodRst;
      t2_q              <= T2_W'(RmsThresholdRst) * T2_W'(RmsThresholdRst);
    end else begin
      t2_q <= T2_W'(rms_threshold_q) * T2_W'(rms_threshold_q);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgChunkSamples:   chunk_samples_q   <= cfg_data_i[LEN_CFG_W-1:0];
          CfgRmsThreshold:   rms_threshold_q   <= cfg_data_i[THR_W-1:0];
          CfgDetectEnable:   detect_enable_q   <= cfg_data_i[0];
          CfgDecisionPeriod: decision_period_q <= cfg_data_i[PERIOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // flow control from the result register back to the input
  always_comb begin
    adv_out  = !ov_q || out_ch.ready;
    en4      = !v4_q || adv_out;
    en3      = !v3_q || en4;
    len_cfg  = LEN_W'(chunk_samples_q);
    if (len_cfg == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_cfg > LEN_W'(MaxChunkSamples)) begin
      eff_len = LEN_W'(MaxChunkSamples);
    end else begin
      eff_len = len_cfg;
    end
    count_d    = count_q + CNT_W'(1);
    chunk_end  = LEN_W'(count_d) >= eff_len;
    go2        = v2_q && (!chunk_end || en3);
    en2        = !v2_q || go2;
    in_ready   = !v1_q || en2;
    mag        = s1_sample_q[SAMPLE_W-1] ? SAMPLE_W'(~s1_sample_q + SAMPLE_W'(1))
                                         : SAMPLE_W'(s1_sample_q);
    energy_sum = {1'b0, energy_q} + (ENERGY_W+1)'(s2_sq_q);
    energy_d   = energy_sum[ENERGY_W] ? EnergyMax : energy_sum[ENERGY_W-1:0];
  end

  assign in_ch.ready = in_ready;

  // valid flags of all stages, and the chunk energy and count accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      ov_q     <= 1'b0;
      energy_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_ready) v1_q <= in_ch.valid;
      if (en2)      v2_q <= v1_q;
      if (en3)      v3_q <= go2 && chunk_end;
      if (en4)      v4_q <= v3_q;
      if (adv_out)  ov_q <= v4_q;
      if (go2) begin
        if (chunk_end) begin
          energy_q <= '0;
          count_q  <= '0;
        end else begin
          energy_q <= energy_d;
          count_q  <= count_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch.valid) begin
      s1_sample_q <= in_ch.sample;
      s1_mute_q   <= in_ch.mute;
    end
    if (en2 && v1_q) begin
      s2_sq_q   <= SQ_W'(mag) * SQ_W'(mag);
      s2_mute_q <= s1_mute_q;
    end
    if (go2 && chunk_end) begin
      s3_energy_q <= energy_d;
      s3_count_q  <= count_d;
      s3_mute_q   <= s2_mute_q;
    end
    if (en4 && v3_q) begin
      s4_q.energy <= s3_energy_q;
      s4_q.limit  <= PROD_W'(t2_q) * PROD_W'(s3_count_q);
      s4_q.mute   <= s3_mute_q;
    end
    if (adv_out && v4_q) begin
      out_q <= result;
    end
  end

  evag_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv_out && v4_q),
    .chunk_i  (s4_q),
    .detect_i (detect_enable_q),
    .period_i (decision_period_q),
    .result_o (result)
  );

  assign out_ch.valid            = ov_q;
  assign out_ch.chunk_is_speech  = out_q.chunk_is_speech;
  assign out_ch.speaking_changed = out_q.speaking_changed;
  assign out_ch.speaking_now     = out_q.speaking_now;

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the energy voice activity gate beat by beat against a chunk energy
// predictor. The run opens with hand-picked chunks at the default threshold,
// detect and period, the threshold edges, a chunk length of zero, a period
// cut below the tally and a length cut mid-chunk. Random phases with random
// settings follow. Sample beats come in bursts with gaps, decision beats are
// taken on a stall pattern, and one long hold-off backs the gate up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import evag_pkg::*;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandomItems  = 600;
  localparam int unsigned CycleLimit   = 1000000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       mute;
  } sample_beat_t;

  class gate_scoreboard;
    logic [LEN_CFG_W-1:0] chunk_len;
    logic [THR_W-1:0]     threshold;
    logic                 detect_on;
    logic [PERIOD_W-1:0]  period;
    logic [ENERGY_W-1:0]  energy;
    int unsigned          count;
    logic [PERIOD_W-1:0]  tally;
    logic                 speaking;
    result_t              pending[$];
    int unsigned          errors;

    function new();
      chunk_len = ChunkSamplesRst;
      threshold = RmsThresholdRst;
      detect_on = DetectEnableRst;
      period    = DecisionPeriodRst;
      energy    = '0;
      count     = 0;
      tally     = '0;
      speaking  = 1'b0;
      errors    = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CfgChunkSamples:   chunk_len = data[LEN_CFG_W-1:0];
        CfgRmsThreshold:   threshold = data[THR_W-1:0];
        CfgDetectEnable:   detect_on = data[0];
        CfgDecisionPeriod: period = data[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(sample_beat_t beat);
      int                  s;
      longint unsigned     mag;
      longint unsigned     sum;
      longint unsigned     thr;
      int unsigned         len;
      logic [PERIOD_W-1:0] per;
      result_t             res;
      s   = beat.sample;
      mag = (s < 0) ? -s : s;
      sum = longint'(energy) + mag * mag;
      energy = (sum > EnergyMax) ? EnergyMax : sum[ENERGY_W-1:0];
      count++;
      len = (chunk_len == 0) ? 1 :
            ((chunk_len > MaxChunkSamples) ? MaxChunkSamples : chunk_len);
      if (count < len) return;
      res = '0;
      if (beat.mute) begin
        if (speaking) begin
          speaking = 1'b0;
          res.speaking_changed = 1'b1;
        end
      end else begin
        thr = threshold;
        res.chunk_is_speech = !detect_on || (longint'(energy) > thr * thr * count);
        per = (period == '0) ? PERIOD_W'(1) : period;
        tally++;
        if (tally >= per) begin
          tally = '0;
          if (res.chunk_is_speech != speaking) begin
            speaking = res.chunk_is_speech;
            res.speaking_changed = 1'b1;
          end
        end
      end
      res.speaking_now = speaking;
      energy = '0;
      count  = 0;
      pending.push_back(res);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("ERROR at %0t: %s", $time, what);
    endtask

    task check_decision(result_t seen);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch("decision beat with no chunk finished");
        return;
      end
      want = pending.pop_front();
      if (seen.chunk_is_speech !== want.chunk_is_speech)
        report_mismatch($sformatf("chunk_is_speech %b, expected %b",
                                  seen.chunk_is_speech, want.chunk_is_speech));
      if (seen.speaking_changed !== want.speaking_changed)
        report_mismatch($sformatf("speaking_changed %b, expected %b",
                                  seen.speaking_changed, want.speaking_changed));
      if (seen.speaking_now !== want.speaking_now)
        report_mismatch($sformatf("speaking_now %b, expected %b",
                                  seen.speaking_now, want.speaking_now));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  evag_in_if  in_ch ();
  evag_out_if out_ch ();

  energy_voice_activity_gate u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  gate_scoreboard scoreboard;
  sample_beat_t   sample_queue[$];
  bit             hold_request;
  int unsigned    cycle_count;
  int unsigned    gen_len;
  int unsigned    gen_pos;
  int unsigned    chunk_style;
  int unsigned    current_threshold;
  int unsigned    random_items;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      scoreboard.check_decision(result_t'{chunk_is_speech:  out_ch.chunk_is_speech,
                                          speaking_changed: out_ch.speaking_changed,
                                          speaking_now:     out_ch.speaking_now});
  end

  initial begin : sample_sender
    int unsigned burst_left;
    int unsigned gap_left;
    bit          accepted;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.mute   = 1'b0;
    burst_left   = 0;
    gap_left     = 0;
    forever begin
      @(posedge clk_i);
      accepted = in_ch.valid && in_ch.ready;
      if (accepted) scoreboard.note_sample(sample_queue.pop_front());
      @(negedge clk_i);
      if (!in_ch.valid || accepted) begin
        if (gap_left == 0 && sample_queue.size() > 0) begin
          in_ch.valid  <= 1'b1;
          in_ch.sample <= sample_queue[0].sample;
          in_ch.mute   <= sample_queue[0].mute;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
        end else begin
          in_ch.valid  <= 1'b0;
          in_ch.sample <= SAMPLE_W'($urandom);
          in_ch.mute   <= 1'($urandom);
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  initial begin : decision_receiver
    logic [15:0] stall_bits;
    int unsigned bit_pos;
    int unsigned hold_left;
    bit          hold_done;
    out_ch.ready = 1'b0;
    stall_bits   = '1;
    bit_pos      = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (bit_pos == 0)
          stall_bits = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom | $urandom);
        out_ch.ready <= stall_bits[bit_pos];
        bit_pos = (bit_pos + 1) % 16;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] styled_sample(int unsigned style,
                                                               int unsigned thr);
    int mag;
    int v;
    if (style == 0) return SAMPLE_W'($urandom);
    if (style == 1) mag = $urandom_range(0, thr / 2);
    else if (style == 2) mag = thr + $urandom_range(0, 1);
    else if (style == 3) mag = $urandom_range((thr < 32767) ? thr + 1 : 32767, 32768);
    else mag = $urandom_range(0, 1) ? 32768 - $urandom_range(0, 1) : $urandom_range(0, 1);
    v = $urandom_range(0, 1) ? -mag : mag;
    if (v > 32767) v = -v;
    return SAMPLE_W'(v);
  endfunction

  task automatic push_sample(int v, bit mute);
    sample_queue.push_back('{sample: SAMPLE_W'(v), mute: mute});
  endtask

  // alternating sign keeps the energy fixed while the sample bits move
  task automatic queue_chunk(int unsigned len, int mag, bit mute_last);
    int v;
    for (int unsigned i = 0; i < len; i++) begin
      v = i[0] ? -mag : mag;
      if (v > 32767) v = -v;
      push_sample(v, (i == len - 1) ? mute_last : 1'($urandom));
    end
  endtask

  task automatic queue_random_samples(int unsigned n);
    sample_beat_t beat;
    for (int unsigned i = 0; i < n; i++) begin
      if (gen_pos == 0) chunk_style = $urandom_range(0, 4);
      beat.sample = styled_sample(chunk_style, current_threshold);
      beat.mute   = (gen_pos == gen_len - 1) ? ($urandom_range(0, 4) == 0) : 1'($urandom);
      sample_queue.push_back(beat);
      gen_pos = (gen_pos + 1) % gen_len;
    end
  endtask

  task automatic write_register(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    scoreboard.set_register(idx, CFG_DATA_W'(value));
  endtask

  task automatic configure(int unsigned len, int unsigned thr, int unsigned det,
                           int unsigned per);
    write_register(CfgChunkSamples, len);
    write_register(CfgRmsThreshold, thr);
    write_register(CfgDetectEnable, det);
    write_register(CfgDecisionPeriod, per);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gen_len = (len == 0) ? 1 : ((len > MaxChunkSamples) ? MaxChunkSamples : len);
    gen_pos = 0;
    current_threshold = thr;
  endtask

  task automatic wait_idle(int unsigned limit);
    int unsigned waited;
    waited = 0;
    while ((sample_queue.size() != 0 || scoreboard.pending.size() != 0) && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : main_sequence
    int unsigned len;
    int unsigned thr;
    int unsigned per;
    int unsigned n;
    int unsigned r;
    scoreboard        = new();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgChunkSamples;
    cfg_data_i        = '0;
    hold_request      = 1'b0;
    gen_len           = 512;
    gen_pos           = 0;
    chunk_style       = 0;
    current_threshold = 800;
    random_items      = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // default threshold, detect and period: level at the threshold, above it,
    // then a muted chunk
    write_register(CfgChunkSamples, 4);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    queue_chunk(4, 800, 1'b0);
    repeat (3) queue_chunk(4, 801, 1'b0);
    queue_chunk(4, 801, 1'b1);
    wait_idle(CycleLimit);

    // zero length and zero period act as one
    configure(0, 100, 1, 0);
    push_sample(100, 1'b0);
    push_sample(101, 1'b0);
    push_sample(-101, 1'b0);
    push_sample(101, 1'b1);
    push_sample(0, 1'b1);
    push_sample(-32768, 1'b0);
    push_sample(32767, 1'b0);
    push_sample(0, 1'b0);
    wait_idle(CycleLimit);

    configure(1, 0, 1, 1);
    push_sample(0, 1'b0);
    push_sample(1, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(0, 1'b0);
    wait_idle(CycleLimit);

    configure(1, 32767, 1, 1);
    push_sample(-32768, 1'b0);
    push_sample(32767, 1'b0);
    wait_idle(CycleLimit);

    // detection off, then the period cut below the tally
    configure(1, 32767, 0, 15);
    repeat (5) push_sample(0, 1'b0);
    wait_idle(CycleLimit);
    configure(1, 32767, 0, 2);
    push_sample(0, 1'b0);
    wait_idle(CycleLimit);

    // length cut below the count already taken
    configure(6, 200, 1, 1);
    repeat (4) push_sample(300, 1'b0);
    wait_idle(CycleLimit);
    configure(2, 200, 1, 1);
    push_sample(-300, 1'b0);
    push_sample(10, 1'b0);
    push_sample(-10, 1'b1);
    wait_idle(CycleLimit);

    // long receiver hold-off with one decision per sample
    configure(1, $urandom_range(0, 32767), 1, 2);
    hold_request = 1'b1;
    queue_random_samples(80);
    random_items += 80;
    wait_idle(CycleLimit);

    while (random_items < RandomItems) begin
      r = $urandom_range(0, 9);
      if (r == 0) len = 0;
      else if (r <= 6) len = $urandom_range(1, 6);
      else if (r <= 8) len = $urandom_range(7, 16);
      else len = $urandom_range(17, 40);
      r = $urandom_range(0, 9);
      if (r == 0) thr = 0;
      else if (r == 1) thr = 32767;
      else if (r <= 4) thr = $urandom_range(1, 2000);
      else thr = $urandom_range(0, 32767);
      per = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(0, 15);
      configure(len, thr, ($urandom_range(0, 4) != 0), per);
      n = $urandom_range(30, 80);
      queue_random_samples(n);
      random_items += n;
      wait_idle(CycleLimit);
    end

    wait_idle(20000);
    if (scoreboard.pending.size() != 0)
      scoreboard.report_mismatch($sformatf("%0d chunk decisions never arrived",
                                           scoreboard.pending.size()));
    if (scoreboard.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### energy_voice_activity_gate.f
rtl/evag_pkg.sv
rtl/evag_ifs.sv
rtl/evag_decide.sv
rtl/energy_voice_activity_gate.sv
bench/testbench.sv
